// ===== design/bvl_pkg.sv =====
// Shared constants, types and helpers for the basename version lookup block.
// No dependencies.
`default_nettype none

package bvl_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 16;
  localparam int NAME_BYTES    = 14;

  localparam int ENTRY_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int LEN_W   = $clog2(NAME_BYTES);   // holds 0 .. NAME_BYTES-1
  localparam int BUF_BYTES = NAME_BYTES - 1;     // longest accepted basename

  // Operation codes
  typedef enum logic [1:0] {
    OP_PATH    = 2'd0,
    OP_NAME    = 2'd1,
    OP_VERSION = 2'd2
  } op_e;

  // Character codes
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  typedef logic [NAME_BYTES-1:0][7:0] name_row_t;

  typedef struct packed {
    logic [BUF_BYTES-1:0][7:0] bytes;
    logic [LEN_W-1:0]          len;
    logic                      too_long;
  } basename_t;

  typedef struct packed {
    logic               en;
    logic [ENTRY_W-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    name_row_t   name;
    logic [15:0] version;
  } tbl_row_t;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_READ,
    SCAN_LAST,
    SCAN_DONE
  } scan_state_e;

  function automatic logic [7:0] to_upper(input logic [7:0] ch);
    logic [7:0] res;
    res = ch;
    if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
      res = ch - CASE_OFFSET;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/bvl_table.sv =====
// Name and version memories with per-byte and per-entry valid flags.
// Depends on bvl_pkg.
`default_nettype none

module bvl_table (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             name_we_i,
  input  wire logic             ver_we_i,
  input  wire logic [3:0]       entry_index_i,
  input  wire logic [3:0]       char_position_i,
  input  wire logic [7:0]       char_value_i,
  input  wire logic [15:0]      ver_wdata_i,
  input  wire bvl_pkg::tbl_rd_t rd_i,
  output bvl_pkg::tbl_row_t     row_o
);
  import bvl_pkg::*;

  // One bit above the address so the bound itself fits
  localparam int IDX_W = (ENTRY_W + 1 > 4) ? ENTRY_W + 1 : 4;
  localparam int POS_W = (LEN_W + 1 > 4) ? LEN_W + 1 : 4;

  name_row_t   name_mem [TABLE_ENTRIES];
  logic [15:0] ver_mem  [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0][NAME_BYTES-1:0] byte_vld_q;
  logic [TABLE_ENTRIES-1:0]                 ver_vld_q;

  logic [IDX_W-1:0]   idx_ext;
  logic [POS_W-1:0]   pos_ext;
  logic               idx_ok, pos_ok;
  logic [ENTRY_W-1:0] wr_row;
  logic [LEN_W-1:0]   wr_col;

  name_row_t           rd_name_q;
  logic [NAME_BYTES-1:0] rd_bvld_q;
  logic [15:0]         rd_ver_q;
  logic                rd_vvld_q;

  assign idx_ext = IDX_W'(entry_index_i);
  assign pos_ext = POS_W'(char_position_i);
  assign idx_ok  = idx_ext < IDX_W'(TABLE_ENTRIES);
  assign pos_ok  = pos_ext < POS_W'(NAME_BYTES);
  assign wr_row  = idx_ext[ENTRY_W-1:0];
  assign wr_col  = pos_ext[LEN_W-1:0];

  // Memory arrays
  always_ff @(posedge clk_i) begin
    if (name_we_i && idx_ok && pos_ok) begin
      name_mem[wr_row][wr_col] <= char_value_i;
    end
    if (ver_we_i && idx_ok) begin
      ver_mem[wr_row] <= ver_wdata_i;
    end
    if (rd_i.en) begin
      rd_name_q <= name_mem[rd_i.addr];
      rd_ver_q  <= ver_mem[rd_i.addr];
    end
  end

  // Valid flags stand in for clearing the arrays at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= '0;
      ver_vld_q  <= '0;
      rd_bvld_q  <= '0;
      rd_vvld_q  <= 1'b0;
    end else begin
      if (name_we_i && idx_ok && pos_ok) begin
        byte_vld_q[wr_row][wr_col] <= 1'b1;
      end
      if (ver_we_i && idx_ok) begin
        ver_vld_q[wr_row] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_bvld_q <= byte_vld_q[rd_i.addr];
        rd_vvld_q <= ver_vld_q[rd_i.addr];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NAME_BYTES; k++) begin
      row_o.name[k] = rd_bvld_q[k] ? rd_name_q[k] : 8'h00;
    end
    row_o.version = rd_vvld_q ? rd_ver_q : 16'h0000;
  end

endmodule

`default_nettype wire

// ===== design/bvl_capture.sv =====
// Captures the final path component, upper-cased, with its length.
// Depends on bvl_pkg.
`default_nettype none

module bvl_capture (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       char_we_i,   // accepted non-NUL path character
  input  wire logic [7:0] char_value_i,
  input  wire logic       clear_i,     // end of lookup
  output bvl_pkg::basename_t base_o
);
  import bvl_pkg::*;

  logic [BUF_BYTES-1:0][7:0] bytes_q;
  logic [LEN_W-1:0]          len_q, len_d;
  logic                      too_long_q, too_long_d;
  logic                      is_sep, store;

  assign is_sep = (char_value_i == CHAR_BSLASH) || (char_value_i == CHAR_SLASH) ||
                  (char_value_i == CHAR_COLON);

  always_comb begin
    len_d      = len_q;
    too_long_d = too_long_q;
    store      = 1'b0;
    if (clear_i) begin
      len_d      = '0;
      too_long_d = 1'b0;
    end else if (char_we_i) begin
      if (is_sep) begin
        len_d      = '0;
        too_long_d = 1'b0;
      end else if (!too_long_q) begin
        if (len_q == LEN_W'(NAME_BYTES - 1)) begin
          too_long_d = 1'b1;
        end else begin
          store = 1'b1;
          len_d = len_q + LEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      too_long_q <= 1'b0;
    end else begin
      len_q      <= len_d;
      too_long_q <= too_long_d;
    end
  end

  // Stale bytes past len are never compared
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < BUF_BYTES; k++) begin
      if (store && len_q == LEN_W'(k)) begin
        bytes_q[k] <= to_upper(char_value_i);
      end
    end
  end

  assign base_o.bytes    = bytes_q;
  assign base_o.len      = len_q;
  assign base_o.too_long = too_long_q;

endmodule

`default_nettype wire

// ===== design/bvl_scan.sv =====
// Table scan sequencer, entry comparator and result register.
// Depends on bvl_pkg.
`default_nettype none

module bvl_scan (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire bvl_pkg::basename_t base_i,
  input  wire bvl_pkg::tbl_row_t  row_i,
  output bvl_pkg::tbl_rd_t        rd_o,
  output logic                    busy_o,
  output logic                    clear_o,
  input  wire logic               out_stall_i,
  output logic                    out_valid_o,
  output logic                    found_o,
  output logic [15:0]             version_word_o
);
  import bvl_pkg::*;

  scan_state_e        state_q, state_d;
  logic [ENTRY_W-1:0] cnt_q, cnt_d;
  logic               pend_q;
  logic               hit_q, hit_d;
  logic [15:0]        word_q, word_d;
  logic               out_valid_q, out_valid_d;
  logic               found_q;
  logic [15:0]        ver_q;
  logic               match, load;

  // Entry compare: non-empty entry, basename not too long, exact bytes up to len, then a zero byte
  always_comb begin
    match = (row_i.name[0] != CHAR_NUL) && !base_i.too_long;
    for (int k = 0; k < BUF_BYTES; k++) begin
      if (LEN_W'(k) < base_i.len && row_i.name[k] != base_i.bytes[k]) begin
        match = 1'b0;
      end
    end
    for (int k = 0; k < NAME_BYTES; k++) begin
      if (LEN_W'(k) == base_i.len && row_i.name[k] != CHAR_NUL) begin
        match = 1'b0;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SCAN_IDLE: if (start_i) state_d = SCAN_READ;
      SCAN_READ: if (cnt_q == ENTRY_W'(TABLE_ENTRIES - 1)) state_d = SCAN_LAST;
      SCAN_LAST: state_d = SCAN_DONE;
      SCAN_DONE: if (!out_valid_q || !out_stall_i) state_d = SCAN_IDLE;
      default:   state_d = SCAN_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    rd_o.en   = 1'b0;
    rd_o.addr = cnt_q;
    cnt_d     = cnt_q;
    hit_d     = hit_q;
    word_d    = word_q;
    load      = 1'b0;
    unique case (state_q)
      SCAN_IDLE: begin
        cnt_d  = '0;
        hit_d  = 1'b0;
        word_d = '0;
      end
      SCAN_READ: begin
        rd_o.en = 1'b1;
        cnt_d   = cnt_q + ENTRY_W'(1);
      end
      SCAN_LAST: ;
      SCAN_DONE: load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
    // first hit wins
    if (pend_q && !hit_q && match) begin
      hit_d  = 1'b1;
      word_d = row_i.version;
    end
    out_valid_d = load | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SCAN_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= rd_o.en;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    if (load) begin
      found_q <= hit_q;
      ver_q   <= word_q;
    end
  end

  assign busy_o         = (state_q != SCAN_IDLE);
  assign clear_o        = load;
  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign version_word_o = ver_q;

endmodule

`default_nettype wire

// ===== design/basename_version_lookup_top.sv =====
// Basename version lookup, top level.
// A NUL terminator starts a scan of TABLE_ENTRIES entries, one memory read per cycle; its
// result is registered when the scan reaches its final state and the result register is free,
// and input is held off until then.
// Reset is asynchronous: the table reads as all zero at once through valid flags,
// no clearing pass; the captured basename is emptied.
`default_nettype none

module basename_version_lookup_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [3:0]  entry_index_i,
  input  wire logic [3:0]  char_position_i,
  input  wire logic [7:0]  char_value_i,
  input  wire logic [7:0]  major_version_i,
  input  wire logic [7:0]  minor_version_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             found_o,
  output logic [15:0]      version_word_o
);
  import bvl_pkg::*;

  logic      in_xfer;
  logic      is_path, is_term;
  logic      busy, clear;
  basename_t base;
  tbl_rd_t   rd;
  tbl_row_t  row;

  // Only the scan blocks new transfers; a waiting result does not, since
  // the scan itself parks in its final state until the result register frees.
  assign in_stall_o = busy;
  assign in_xfer    = in_valid_i & ~busy;

  assign is_path = in_xfer && (operation_i == OP_PATH);
  assign is_term = is_path && (char_value_i == CHAR_NUL);

  // Name bytes and version words go straight into the memories
  bvl_table u_table (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .name_we_i       (in_xfer && (operation_i == OP_NAME)),
    .ver_we_i        (in_xfer && (operation_i == OP_VERSION)),
    .entry_index_i   (entry_index_i),
    .char_position_i (char_position_i),
    .char_value_i    (char_value_i),
    .ver_wdata_i     ({minor_version_i, major_version_i}),
    .rd_i            (rd),
    .row_o           (row)
  );

  // Basename is held through the scan and emptied when the result is loaded
  bvl_capture u_capture (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_we_i    (is_path && !is_term),
    .char_value_i (char_value_i),
    .clear_i      (clear),
    .base_o       (base)
  );

  // Walks entries in order, keeps the first hit
  bvl_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (is_term),
    .base_i         (base),
    .row_i          (row),
    .rd_o           (rd),
    .busy_o         (busy),
    .clear_o        (clear),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .found_o        (found_o),
    .version_word_o (version_word_o)
  );

endmodule

`default_nettype wire
